// ===== hw/rtl/dpbf_pkg.sv =====
// ============================================================================
// dpbf_pkg: shared types and constants of the depth back-projection filter
// Holds register indexes, reset values, widths and the word structs passed
// between the front and back parts and out of the back part.
// ============================================================================
package dpbf_pkg;

   localparam int COORD_BITS_DEF = 10;
   localparam int DEPTH_BITS_DEF = 16;
   localparam int OUT_W = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_CENTER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INVERSE_FOCAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POSE_ROW_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POSE_ROW_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POSE_ROW_Z    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_LIMIT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FAR_LIMIT     = 3'd6;

   localparam logic [31:0] CENTER_RESET = 32'd251139064;
   localparam logic [47:0] INVF_RESET   = 48'd536149523669;
   localparam logic [63:0] ROWX_RESET   = 64'd16384;
   localparam logic [63:0] ROWY_RESET   = 64'd1073741824;
   localparam logic [63:0] ROWZ_RESET   = 64'd70368744177664;
   localparam logic signed [15:0] NEAR_RESET = 16'sd200;
   localparam logic signed [15:0] FAR_RESET  = 16'sd600;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   // Back-projected camera point plus color; camera x/y fit in 44 bits.
   localparam int CAM_W = 44;
   typedef struct packed {
      logic signed [CAM_W-1:0] cam_x;
      logic signed [CAM_W-1:0] cam_y;
      logic [15:0]             cam_z;
      logic [7:0]              red;
      logic [7:0]              green;
      logic [7:0]              blue;
   } cam_word_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] world_x;
      logic signed [OUT_W-1:0] world_y;
      logic signed [OUT_W-1:0] world_z;
      logic [7:0]              red;
      logic [7:0]              green;
      logic [7:0]              blue;
   } point_word_type;

endpackage

// ===== hw/rtl/depth_pixel_backproject_filter.sv =====
// ============================================================================
// depth_pixel_backproject_filter: depth pixel to world point filter
// Back-projects depth pixels, applies a rigid pose and keeps points whose
// world z lies strictly inside a near/far window.
// ============================================================================
//
//   Channel  Direction  Contents
//   req_     in         one pixel word: column, row, depth, RGB
//   rsp_     out        one world point word with its color
//   csr_     in         register writes, index 0..6
//
// One pixel word is accepted every cycle when the result side keeps up.
// A kept pixel reaches rsp_ through three stages of back-projection, a
// four-word queue, and three transform stages.
// Zero-depth pixels and pixels outside the depth window produce no word.
// Reset (synchronous) restores the register defaults and empties the pipe.
// A stalled rsp_ fills the back stages, then the queue, then the front stages, then halts req_.
module depth_pixel_backproject_filter #(
   parameter int COORD_BITS = dpbf_pkg::COORD_BITS_DEF,
   parameter int DEPTH_BITS = dpbf_pkg::DEPTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // column, row_index, depth_mm, red_in, green_in, blue_in (low bit up)
   input  logic [((2*COORD_BITS+DEPTH_BITS+24+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // world_x, world_y, world_z, red_out, green_out, blue_out (low bit up)
   output logic [79:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [dpbf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpbf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   localparam int CB = COORD_BITS;
   localparam int DB = DEPTH_BITS;

   logic [31:0] center_ff;
   logic [47:0] invf_ff;
   logic [63:0] rowx_ff, rowy_ff, rowz_ff;
   logic signed [15:0] near_ff, far_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= dpbf_pkg::CENTER_RESET;
         invf_ff   <= dpbf_pkg::INVF_RESET;
         rowx_ff   <= dpbf_pkg::ROWX_RESET;
         rowy_ff   <= dpbf_pkg::ROWY_RESET;
         rowz_ff   <= dpbf_pkg::ROWZ_RESET;
         near_ff   <= dpbf_pkg::NEAR_RESET;
         far_ff    <= dpbf_pkg::FAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            dpbf_pkg::REG_IMAGE_CENTER:  center_ff <= csr_wdata[31:0];
            dpbf_pkg::REG_INVERSE_FOCAL: invf_ff   <= csr_wdata[47:0];
            dpbf_pkg::REG_POSE_ROW_X:    rowx_ff   <= csr_wdata;
            dpbf_pkg::REG_POSE_ROW_Y:    rowy_ff   <= csr_wdata;
            dpbf_pkg::REG_POSE_ROW_Z:    rowz_ff   <= csr_wdata;
            dpbf_pkg::REG_NEAR_LIMIT:    near_ff   <= csr_wdata[15:0];
            dpbf_pkg::REG_FAR_LIMIT:     far_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   dpbf_pkg::cam_word_type   front_word, back_word;
   dpbf_pkg::point_word_type point;
   logic front_valid, front_ready, back_valid, back_ready;

   dpbf_front #(.COORD_BITS(CB), .DEPTH_BITS(DB)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .column(req_tdata[CB-1:0]),
      .row_index(req_tdata[2*CB-1:CB]),
      .depth_mm(req_tdata[2*CB+DB-1:2*CB]),
      .red_in(req_tdata[2*CB+DB+7:2*CB+DB]),
      .green_in(req_tdata[2*CB+DB+15:2*CB+DB+8]),
      .blue_in(req_tdata[2*CB+DB+23:2*CB+DB+16]),
      .image_center(center_ff), .inverse_focal(invf_ff),
      .out_valid(front_valid), .out_ready(front_ready), .out_word(front_word)
   );

   dpbf_queue u_queue (
      .clock, .reset,
      .in_valid(front_valid), .in_ready(front_ready), .in_word(front_word),
      .out_valid(back_valid), .out_ready(back_ready), .out_word(back_word)
   );

   dpbf_back u_back (
      .clock, .reset,
      .in_valid(back_valid), .in_ready(back_ready), .in_word(back_word),
      .pose_row_x(rowx_ff), .pose_row_y(rowy_ff), .pose_row_z(rowz_ff),
      .near_limit_mm(near_ff), .far_limit_mm(far_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_word(point)
   );

   assign rsp_tdata = {2'b00, point.blue, point.green, point.red,
                       point.world_z, point.world_y, point.world_x};
endmodule

// ===== hw/rtl/dpbf_front.sv =====
// ============================================================================
// dpbf_front: pixel intake and back-projection
// Drops zero-depth pixels and turns the rest into camera points over a
// three-stage pipeline that advances whenever its output can move.
// ============================================================================
module dpbf_front #(
   parameter int COORD_BITS = dpbf_pkg::COORD_BITS_DEF,
   parameter int DEPTH_BITS = dpbf_pkg::DEPTH_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [COORD_BITS-1:0]    column,
   input  logic [COORD_BITS-1:0]    row_index,
   input  logic [DEPTH_BITS-1:0]    depth_mm,
   input  logic [7:0]               red_in,
   input  logic [7:0]               green_in,
   input  logic [7:0]               blue_in,
   input  logic [31:0]              image_center,
   input  logic [47:0]              inverse_focal,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dpbf_pkg::cam_word_type   out_word
);
   localparam int CW = dpbf_pkg::CAM_W;

   logic advance;
   // Stage 1: offsets from the image center, Q.4, 19 bits signed so that
   // the widest coordinate setting still fits.
   logic                v1_ff;
   logic signed [18:0]  du_ff, dv_ff;
   logic [15:0]         d1_ff;
   logic [23:0]         col1_ff;
   // Stage 2: offset times depth.
   logic                v2_ff;
   logic signed [35:0]  pdx_ff, pdy_ff;
   logic [15:0]         d2_ff;
   logic [23:0]         col2_ff;
   // Stage 3: times inverse focal length, shifted.
   logic                v3_ff;
   dpbf_pkg::cam_word_type w3_ff;

   logic signed [18:0] du_in, dv_in;
   logic signed [60:0] mx, my;

   assign advance = !v3_ff || out_ready;
   assign in_ready = advance;
   assign out_valid = v3_ff;
   assign out_word = w3_ff;

   assign du_in = $signed({1'b0, 18'(column) << 4})
                - $signed({3'd0, image_center[15:0]});
   assign dv_in = $signed({1'b0, 18'(row_index) << 4})
                - $signed({3'd0, image_center[31:16]});
   assign mx = pdx_ff * $signed({1'b0, inverse_focal[23:0]});
   assign my = pdy_ff * $signed({1'b0, inverse_focal[47:24]});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid && (depth_mm != '0);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         du_ff   <= du_in;
         dv_ff   <= dv_in;
         d1_ff   <= 16'(depth_mm);
         col1_ff <= {red_in, green_in, blue_in};
         pdx_ff  <= du_ff * $signed({1'b0, d1_ff});
         pdy_ff  <= dv_ff * $signed({1'b0, d1_ff});
         d2_ff   <= d1_ff;
         col2_ff <= col1_ff;
         w3_ff.cam_x <= CW'(mx >>> 28);
         w3_ff.cam_y <= CW'(my >>> 28);
         w3_ff.cam_z <= d2_ff;
         w3_ff.red   <= col2_ff[23:16];
         w3_ff.green <= col2_ff[15:8];
         w3_ff.blue  <= col2_ff[7:0];
      end
   end
endmodule

// ===== hw/rtl/dpbf_queue.sv =====
// ============================================================================
// dpbf_queue: short word queue between front and back
// A small circular buffer that lets either side stall on its own.
// ============================================================================
module dpbf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dpbf_pkg::cam_word_type in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dpbf_pkg::cam_word_type out_word
);
   localparam int AW = dpbf_pkg::QUEUE_AW;

   dpbf_pkg::cam_word_type mem_ff [dpbf_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(dpbf_pkg::QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_word  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_word;
   end
endmodule

// ===== hw/rtl/dpbf_back.sv =====
// ============================================================================
// dpbf_back: rigid transform, depth window and saturation
// Multiplies the camera point by the pose, tests world z against the limits
// and saturates the point into the output register.
// ============================================================================
module dpbf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  dpbf_pkg::cam_word_type   in_word,
   input  logic [63:0]              pose_row_x,
   input  logic [63:0]              pose_row_y,
   input  logic [63:0]              pose_row_z,
   input  logic signed [15:0]       near_limit_mm,
   input  logic signed [15:0]       far_limit_mm,
   output logic                     out_valid,
   input  logic                     out_ready,
   output dpbf_pkg::point_word_type out_word
);
   localparam int OW = dpbf_pkg::OUT_W;
   localparam int PW = dpbf_pkg::CAM_W + 16;   // product width
   localparam int SW = PW + 2;                 // sum of three

   logic advance;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] p_ff [3][3];
   logic [23:0] col1_ff, col2_ff;
   logic signed [SW-1:0] w_ff [3];
   logic signed [SW-1:0] w_in [3];
   logic [63:0] rows [3];
   dpbf_pkg::point_word_type out_ff;

   assign rows[0] = pose_row_x;
   assign rows[1] = pose_row_y;
   assign rows[2] = pose_row_z;
   assign advance = !v3_ff || out_ready;
   assign in_ready = advance;
   assign out_valid = v3_ff;
   assign out_word = out_ff;

   function automatic logic signed [OW-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      hi = SW'(2**(OW-1) - 1);
      lo = -SW'(2**(OW-1));
      if (v > hi) sat = OW'(hi);
      else if (v < lo) sat = OW'(lo);
      else sat = OW'(v);
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         w_in[r] = ((SW'(p_ff[r][0]) + SW'(p_ff[r][1]) + SW'(p_ff[r][2])) >>> 14)
                   + SW'($signed(rows[r][63:48]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && (w_ff[2] > SW'(near_limit_mm))
                        && (w_ff[2] < SW'(far_limit_mm));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[r][0] <= $signed(rows[r][15:0])  * in_word.cam_x;
            p_ff[r][1] <= $signed(rows[r][31:16]) * in_word.cam_y;
            p_ff[r][2] <= $signed(rows[r][47:32]) * $signed({1'b0, in_word.cam_z});
            w_ff[r] <= w_in[r];
         end
         col1_ff <= {in_word.red, in_word.green, in_word.blue};
         col2_ff <= col1_ff;
         out_ff.world_x <= sat(w_ff[0]);
         out_ff.world_y <= sat(w_ff[1]);
         out_ff.world_z <= sat(w_ff[2]);
         out_ff.red   <= col2_ff[23:16];
         out_ff.green <= col2_ff[15:8];
         out_ff.blue  <= col2_ff[7:0];
      end
   end
endmodule
